>>> rtl/wfr_pkg.sv
// Shared types and codes for the websocket frame receiver.
// Used by the receiver top level and its port checker; no dependencies.
package wfr_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    localparam logic [1:0] ST_OPEN    = 2'd0;
    localparam logic [1:0] ST_CLOSING = 2'd1;
    localparam logic [1:0] ST_DEAD    = 2'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_ERROR   = 3'd1;
    localparam logic [2:0] EV_TEXT    = 3'd2;
    localparam logic [2:0] EV_BINARY  = 3'd3;
    localparam logic [2:0] EV_TOOLONG = 3'd4;
    localparam logic [2:0] EV_CLOSE   = 3'd5;
    localparam logic [2:0] EV_PONG    = 3'd6;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [63:0] ECHO_MAX = 64'd125;
    localparam logic [63:0] LIMIT_SLACK = 64'd16;
    localparam logic [31:0] MAX_MSG_RESET = 32'd65536;

endpackage

>>> rtl/websocket_frame_receiver.sv
// Websocket frame receiver: header decode, unmasking and frame events.
// Depends on wfr_pkg; checked by wfr_checker (bound from its own file).
//
// Usage:
//   Input channel rx_byte/rx_valid/rx_ready carries one received stream byte
//   per transfer. Each accepted byte produces exactly one result on the
//   output channel (data_byte, data_valid, data_kind, event_code,
//   echo_length, link_status with out_valid/out_ready).
//   The result of a byte is registered for the cycle after its transfer.
//   Throughput: one byte per cycle while results are taken. Header decode,
//   the 64-bit length checks and the unmask XOR sit in one combinational pass
//   between the parse state registers and the result register.
//   Stall: rx_ready stays high while the result register is empty or being
//   taken in the same cycle; when the receiver holds out_ready low with a
//   result pending, rx_ready drops and the result is held unchanged.
//   Reset (rst_n low, asynchronous): parser waits for the first header byte,
//   no message in progress, link open, max_message_bytes = 65536.
//   Configuration: cfg_write_en loads cfg_write_data into max_message_bytes
//   at the clock edge; write only while no byte is in flight.
//   After an error, a close or an overflow, later bytes give results that
//   are all zero except link_status.
module websocket_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic [7:0]  rx_byte,
    input  logic        rx_valid,
    output logic        rx_ready,
    output logic [7:0]  data_byte,
    output logic        data_valid,
    output logic        data_kind,
    output logic [2:0]  event_code,
    output logic [6:0]  echo_length,
    output logic [1:0]  link_status,
    output logic        out_valid,
    input  logic        out_ready
);
    import wfr_pkg::*;

    // parse state
    phase_t      phase_reg,  phase_next;
    logic [3:0]  hdr_idx_reg, hdr_idx_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        final_reg,  final_next;
    logic        masked_reg, masked_next;
    logic [63:0] plen_reg,   plen_next;
    logic [63:0] ppos_reg,   ppos_next;
    logic [31:0] mask_reg,   mask_next;
    logic [1:0]  mkind_reg,  mkind_next;
    logic [32:0] mlen_reg,   mlen_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] max_reg;

    // result register
    logic        out_valid_reg;
    logic [7:0]  data_byte_reg;
    logic        data_valid_reg;
    logic        data_kind_reg;
    logic [2:0]  event_code_reg;
    logic [6:0]  echo_length_reg;
    logic [1:0]  link_status_reg;

    // decode flags
    logic        accept;
    logic        is_open;
    logic        len_done;
    logic        mask_done;
    logic        end_frame;
    logic        hdr_err;
    logic        overflow;
    logic        data_op;
    logic        ctrl_echo;
    logic [63:0] plen_new;
    logic        masked_new;
    logic [63:0] msg_sum;
    logic [63:0] ppos_inc;
    logic [3:0]  hdr_idx_inc;
    logic [6:0]  len7;
    logic [7:0]  key_byte;

    // result fields for the byte being taken
    logic [7:0]  r_byte;
    logic        r_valid;
    logic        r_kind;
    logic [2:0]  r_event;
    logic [6:0]  r_echo;

    assign rx_ready = !out_valid_reg || out_ready;
    assign accept   = rx_valid && rx_ready;
    assign is_open  = (status_reg == ST_OPEN);

    // Decode: length assembly, header checks and frame-end detection.
    always_comb
    begin
        len7        = rx_byte[6:0];
        msg_sum     = 64'(mlen_reg) + plen_reg;   // wraps at 64 bits
        overflow    = msg_sum > {32'd0, max_reg};
        ppos_inc    = ppos_reg + 64'd1;
        hdr_idx_inc = hdr_idx_reg + 4'd1;
        data_op     = (opcode_reg <= OP_BINARY);
        ctrl_echo   = ((opcode_reg == OP_CLOSE) || (opcode_reg == OP_PING))
                      && (plen_reg <= ECHO_MAX);
        plen_new    = plen_reg;
        masked_new  = masked_reg;
        len_done    = 1'b0;
        mask_done   = 1'b0;
        end_frame   = 1'b0;
        unique case (phase_reg)
            PH_HDR0:
            begin
            end
            PH_HDR1:
            begin
                masked_new = rx_byte[7];
                if ((len7 == LEN_EXT16) || (len7 == LEN_EXT64))
                begin
                    plen_new = 64'd0;
                end
                else
                begin
                    plen_new = 64'(len7);
                    len_done = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                plen_new = {plen_reg[55:0], rx_byte};
                len_done = (hdr_idx_reg <= 4'd1);
            end
            PH_MASK:
            begin
                mask_done = (hdr_idx_inc >= 4'd4);
                end_frame = mask_done && (plen_reg == 64'd0);
            end
            default:
            begin
                end_frame = (ppos_inc >= plen_reg);
            end
        endcase
        if (!is_open)
        begin
            len_done  = 1'b0;
            end_frame = 1'b0;
            mask_done = 1'b0;
        end
        hdr_err = !masked_new
                  || (plen_new > (64'(max_reg) + LIMIT_SLACK))
                  || ((opcode_reg >= 4'd3) && (opcode_reg <= 4'd7))
                  || (opcode_reg >= 4'hB)
                  || (((opcode_reg == OP_TEXT) || (opcode_reg == OP_BINARY))
                      && (mkind_reg != 2'd0))
                  || ((opcode_reg == OP_CONT) && (mkind_reg == 2'd0));
    end

    // Next state.
    always_comb
    begin
        phase_next  = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        opcode_next = opcode_reg;
        final_next  = final_reg;
        masked_next = masked_reg;
        plen_next   = plen_reg;
        ppos_next   = ppos_reg;
        mask_next   = mask_reg;
        mkind_next  = mkind_reg;
        mlen_next   = mlen_reg;
        status_next = status_reg;
        if (is_open)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    final_next  = rx_byte[7];
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked_next = masked_new;
                    plen_next   = plen_new;
                    if (len7 == LEN_EXT16)
                    begin
                        hdr_idx_next = 4'd2;
                        phase_next   = PH_EXTLEN;
                    end
                    else if (len7 == LEN_EXT64)
                    begin
                        hdr_idx_next = 4'd8;
                        phase_next   = PH_EXTLEN;
                    end
                end
                PH_EXTLEN:
                begin
                    plen_next = plen_new;
                    if (hdr_idx_reg != 4'd0)
                    begin
                        hdr_idx_next = hdr_idx_reg - 4'd1;
                    end
                end
                PH_MASK:
                begin
                    mask_next    = {mask_reg[23:0], rx_byte};
                    hdr_idx_next = hdr_idx_inc;
                    if (mask_done)
                    begin
                        ppos_next = 64'd0;
                        if (plen_reg != 64'd0)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    ppos_next = ppos_inc;
                end
            endcase
        end
        if (end_frame)
        begin
            phase_next = PH_HDR0;
            if (opcode_reg == OP_CLOSE)
            begin
                status_next = ST_CLOSING;
            end
            else if (data_op)
            begin
                if (overflow)
                begin
                    status_next = ST_CLOSING;
                end
                else if (final_reg)
                begin
                    mlen_next  = 33'd0;
                    mkind_next = 2'd0;
                end
                else
                begin
                    mlen_next = msg_sum[32:0];
                end
            end
        end
        if (len_done)
        begin
            if (hdr_err)
            begin
                status_next = ST_DEAD;
                phase_next  = PH_HDR0;
            end
            else
            begin
                phase_next   = PH_MASK;
                hdr_idx_next = 4'd0;
                mask_next    = 32'd0;
                if ((opcode_reg == OP_TEXT) || (opcode_reg == OP_BINARY))
                begin
                    mkind_next = opcode_reg[1:0];
                end
            end
        end
    end

    // Result fields.
    always_comb
    begin
        case (ppos_reg[1:0])
            2'd0:    key_byte = mask_reg[31:24];
            2'd1:    key_byte = mask_reg[23:16];
            2'd2:    key_byte = mask_reg[15:8];
            default: key_byte = mask_reg[7:0];
        endcase
        r_byte  = 8'd0;
        r_valid = 1'b0;
        r_kind  = 1'b0;
        r_event = EV_NONE;
        r_echo  = 7'd0;
        // payload byte: phase is payload when none of the header phases match
        if (is_open && (phase_reg != PH_HDR0) && (phase_reg != PH_HDR1)
            && (phase_reg != PH_EXTLEN) && (phase_reg != PH_MASK))
        begin
            if (data_op)
            begin
                if ((mkind_reg == 2'd1) && !overflow)
                begin
                    r_byte  = rx_byte ^ key_byte;
                    r_valid = 1'b1;
                end
            end
            else if (ctrl_echo)
            begin
                r_byte  = rx_byte ^ key_byte;
                r_valid = 1'b1;
                r_kind  = 1'b1;
            end
        end
        if (end_frame)
        begin
            if ((opcode_reg == OP_CLOSE) || (opcode_reg == OP_PING))
            begin
                r_echo  = (plen_reg > ECHO_MAX) ? 7'd0 : plen_reg[6:0];
                r_event = (opcode_reg == OP_CLOSE) ? EV_CLOSE : EV_PONG;
            end
            else if (data_op)
            begin
                if (overflow)
                begin
                    r_event = EV_TOOLONG;
                end
                else if (final_reg)
                begin
                    r_event = (mkind_reg == 2'd1) ? EV_TEXT : EV_BINARY;
                end
            end
        end
        if (len_done && hdr_err)
        begin
            r_event = EV_ERROR;
        end
    end

    // Parse state and limit register; parse state advances only on an input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            hdr_idx_reg <= 4'd0;
            opcode_reg  <= 4'd0;
            final_reg   <= 1'b0;
            masked_reg  <= 1'b0;
            plen_reg    <= 64'd0;
            ppos_reg    <= 64'd0;
            mask_reg    <= 32'd0;
            mkind_reg   <= 2'd0;
            mlen_reg    <= 33'd0;
            status_reg  <= ST_OPEN;
            max_reg     <= MAX_MSG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_reg <= cfg_write_data;
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                hdr_idx_reg <= hdr_idx_next;
                opcode_reg  <= opcode_next;
                final_reg   <= final_next;
                masked_reg  <= masked_next;
                plen_reg    <= plen_next;
                ppos_reg    <= ppos_next;
                mask_reg    <= mask_next;
                mkind_reg   <= mkind_next;
                mlen_reg    <= mlen_next;
                status_reg  <= status_next;
            end
            // hold the result until taken; refill on every input transfer
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_byte_reg   <= r_byte;
            data_valid_reg  <= r_valid;
            data_kind_reg   <= r_kind;
            event_code_reg  <= r_event;
            echo_length_reg <= r_echo;
            link_status_reg <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = data_byte_reg;
    assign data_valid  = data_valid_reg;
    assign data_kind   = data_kind_reg;
    assign event_code  = event_code_reg;
    assign echo_length = echo_length_reg;
    assign link_status = link_status_reg;

endmodule

>>> rtl/wfr_checker.sv
// Port-level checker for the websocket frame receiver, with its bind.
// Depends on wfr_pkg; attaches to websocket_frame_receiver.
module wfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic [7:0] data_byte,
    input logic       data_valid,
    input logic       data_kind,
    input logic [2:0] event_code,
    input logic [6:0] echo_length,
    input logic [1:0] link_status,
    input logic       out_valid,
    input logic       out_ready
);
    import wfr_pkg::*;

    logic [1:0] last_status_reg;
    logic       out_xfer;

    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_status_reg <= ST_OPEN;
        end
        else if (out_xfer)
        begin
            last_status_reg <= link_status;
        end
    end

    // once closing or dead, the link never changes again
    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (last_status_reg != ST_OPEN)) |-> (link_status == last_status_reg))
        else $error("link_status left closing or dead");

    // bytes after close, overflow or error are ignored
    a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (last_status_reg != ST_OPEN))
        |-> (!data_valid && (event_code == EV_NONE) && (echo_length == 7'd0)))
        else $error("result reported on an ignored byte");

    a_error_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_code == EV_ERROR)) |-> (link_status == ST_DEAD))
        else $error("protocol error without dead link");

    a_echo_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (echo_length != 7'd0))
        |-> ((event_code == EV_CLOSE) || (event_code == EV_PONG)))
        else $error("echo length outside close or pong");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(data_byte)
        && $stable(data_valid) && $stable(data_kind) && $stable(event_code)
        && $stable(echo_length) && $stable(link_status)))
        else $error("stalled result changed");

endmodule

bind websocket_frame_receiver wfr_checker u_wfr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (data_byte),
    .data_valid  (data_valid),
    .data_kind   (data_kind),
    .event_code  (event_code),
    .echo_length (echo_length),
    .link_status (link_status),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
);
